// ===== rtl/sct_pkg.sv =====
// shared types and constants for the source code tokenizer
package sct_pkg;

   localparam int OFFSET_BITS_DEF = 32;
   localparam int LINE_BITS_DEF   = 20;
   localparam int COLUMN_BITS_DEF = 16;
   localparam int MAX_TOKENS      = 3;
   localparam int QUEUE_DEPTH     = 4;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [6:0]  token_kind;
      logic [31:0] start_offset;
      logic [31:0] end_offset;
      logic [19:0] start_line;
      logic [15:0] start_column;
   } tok_type;

   typedef struct packed {
      logic [6:0]  token_kind;
      logic [31:0] start_offset;
      logic [31:0] end_offset;
      logic [19:0] start_line;
      logic [15:0] start_column;
      logic        last_of_run;
   } rsp_type;

   // all tokens caused by one request
   typedef struct packed {
      logic [1:0]                     count;
      tok_type [MAX_TOKENS-1:0]       toks;
   } entry_type;

endpackage

// ===== rtl/sct_lexer.sv =====
// front end: lexer state machine, turns one request into up to three tokens
module sct_lexer import sct_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   output logic      push,
   output entry_type entry
);

   localparam int MAX_FEEDS = 4;

   localparam logic [1:0] RES_DONE  = 2'd0;
   localparam logic [1:0] RES_AGAIN = 2'd1;
   localparam logic [1:0] RES_HELD  = 2'd2;

   localparam logic [6:0] K_EOF = 7'd0, K_ELSE = 7'd1, K_FUN = 7'd2, K_IF = 7'd3,
      K_IDENT = 7'd4, K_WS = 7'd5, K_LINECOM = 7'd6, K_BLOCKCOM = 7'd7, K_DOT3 = 7'd8,
      K_DOT2 = 7'd9, K_DOT = 7'd10, K_INT = 7'd11, K_HEX = 7'd12, K_BIN = 7'd13,
      K_FLOAT = 7'd14, K_DOUBLE = 7'd15, K_STRING = 7'd16, K_TILDE = 7'd17,
      K_EXCLEQ = 7'd18, K_EXCL = 7'd19, K_PCTEQ = 7'd20, K_PCT = 7'd21, K_HATEQ = 7'd22,
      K_HAT = 7'd23, K_ANDAND = 7'd24, K_ANDEQ = 7'd25, K_AND = 7'd26,
      K_STARSTAREQ = 7'd27, K_STARSTAR = 7'd28, K_STAREQ = 7'd29, K_STAR = 7'd30,
      K_LPAREN = 7'd31, K_RPAREN = 7'd32, K_MINUSMINUS = 7'd33, K_MINUSEQ = 7'd34,
      K_ARROW = 7'd35, K_MINUS = 7'd36, K_PLUSPLUS = 7'd37, K_PLUSEQ = 7'd38,
      K_PLUS = 7'd39, K_EQEQ = 7'd40, K_FATARROW = 7'd41, K_EQ = 7'd42, K_OROR = 7'd43,
      K_OREQ = 7'd44, K_OR = 7'd45, K_LSQ = 7'd46, K_RSQ = 7'd47, K_LBRACE = 7'd48,
      K_RBRACE = 7'd49, K_SEMI = 7'd50, K_COLCOL = 7'd51, K_COLON = 7'd52,
      K_SHLEQ = 7'd53, K_SHL = 7'd54, K_LE = 7'd55, K_LMLEQ = 7'd56, K_LML = 7'd57,
      K_LT = 7'd58, K_SHREQ = 7'd59, K_SHR = 7'd60, K_GE = 7'd61, K_GMGEQ = 7'd62,
      K_GMG = 7'd63, K_GT = 7'd64, K_COMMA = 7'd65, K_SLASHEQ = 7'd66, K_SLASH = 7'd67,
      K_QUESTION = 7'd68, K_INVALID = 7'd69;

   localparam logic [5:0] M_IDLE = 6'd0, M_WS = 6'd1, M_SLASH = 6'd2, M_LINECOM = 6'd3,
      M_BLOCKCOM = 6'd4, M_BLOCKSTAR = 6'd5, M_ZERO = 6'd6, M_DEC = 6'd7,
      M_DECPART = 6'd8, M_HEXPRE = 6'd9, M_HEX = 6'd10, M_BINPRE = 6'd11, M_BIN = 6'd12,
      M_DOT = 6'd13, M_DOTDOT = 6'd14, M_STRING = 6'd15, M_IDE = 6'd16, M_IDF = 6'd17,
      M_IDI = 6'd18, M_IDX = 6'd19, M_EXCL = 6'd20, M_PERCENT = 6'd21, M_HAT = 6'd22,
      M_AMP = 6'd23, M_STAR = 6'd24, M_STARSTAR = 6'd25, M_MINUS = 6'd26,
      M_PLUS = 6'd27, M_EQ = 6'd28, M_OR = 6'd29, M_COLON = 6'd30, M_LESS = 6'd31,
      M_LESSLESS = 6'd32, M_LESSMINUS = 6'd33, M_LMLESS = 6'd34, M_GREATER = 6'd35,
      M_GTGT = 6'd36, M_GTMINUS = 6'd37, M_GMGT = 6'd38;

   typedef struct packed {
      logic [5:0]             mode;
      logic [7:0]             held;
      logic                   hcnt;
      logic                   qdbl;
      logic [2:0]             kwp;
      logic [OFFSET_BITS-1:0] tfo;
      logic [LINE_BITS-1:0]   tfl;
      logic [COLUMN_BITS-1:0] tfc;
      logic [OFFSET_BITS-1:0] co;
      logic [LINE_BITS-1:0]   cl;
      logic [COLUMN_BITS-1:0] cc;
   } lex_state_type;

   localparam lex_state_type ST_RESET = '{mode: M_IDLE, held: 8'h00, hcnt: 1'b0,
      qdbl: 1'b0, kwp: 3'd0, tfo: '0, tfl: LINE_BITS'(1), tfc: COLUMN_BITS'(1),
      co: '0, cl: LINE_BITS'(1), cc: COLUMN_BITS'(1)};

   lex_state_type st_ff, st_in;

   function automatic logic is_ws(input logic [7:0] b);
      return b == " " || b == "\t" || b == "\r" || b == "\n";
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] b);
      logic [7:0] l;
      l = b | 8'h20;
      return is_digit(b) || (l >= "a" && l <= "f");
   endfunction

   // folding with 0x20 lets some control bytes through as digits
   function automatic logic ident_cont(input logic [7:0] b);
      logic [7:0] l;
      l = b | 8'h20;
      return b == "_" || (l >= "a" && l <= "z") || (l >= "0" && l <= "9");
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] w);
      case (w)
         2'd0:    return 3'd3;
         2'd1:    return 3'd2;
         2'd2:    return 3'd1;
         default: return 3'd0;
      endcase
   endfunction

   function automatic logic [6:0] kw_kind(input logic [1:0] w);
      case (w)
         2'd0:    return K_ELSE;
         2'd1:    return K_FUN;
         default: return K_IF;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [1:0] p);
      logic [23:0] lse;
      logic [15:0] un;
      lse = "lse";
      un  = "un";
      case (w)
         2'd0: begin
            case (p)
               2'd0:    return lse[23:16];
               2'd1:    return lse[15:8];
               default: return lse[7:0];
            endcase
         end
         2'd1:    return (p == 2'd0) ? un[15:8] : un[7:0];
         2'd2:    return "f";
         default: return 8'h00;
      endcase
   endfunction

   function automatic lex_state_type commit(input lex_state_type s_i, input logic [7:0] b);
      lex_state_type s;
      s = s_i;
      if (s.co != '1) s.co = s.co + 1'b1;
      if (b == "\n") begin
         s.cc = COLUMN_BITS'(1);
         if (s.cl != '1) s.cl = s.cl + 1'b1;
      end else if (s.cc != '1) begin
         s.cc = s.cc + 1'b1;
      end
      return s;
   endfunction

   function automatic tok_type mk_tok(input lex_state_type s, input logic [6:0] k);
      tok_type    t;
      logic [63:0] w;
      t.token_kind = k;
      w = 64'(s.tfo);
      t.start_offset = (w > 64'hFFFF_FFFF) ? '1 : w[31:0];
      w = 64'(s.co);
      t.end_offset = (w > 64'hFFFF_FFFF) ? '1 : w[31:0];
      w = 64'(s.tfl);
      t.start_line = (w > 64'hF_FFFF) ? '1 : w[19:0];
      w = 64'(s.tfc);
      t.start_column = (w > 64'hFFFF) ? '1 : w[15:0];
      return t;
   endfunction

   // one lexer step on one symbol; e marks end of input
   function automatic void feed(input lex_state_type s_i, input logic e,
                                input logic [7:0] b, output lex_state_type s,
                                output logic [1:0] r, output logic em, output tok_type t);
      logic [7:0]       l;
      logic [1:0]       w;
      logic             op_en;
      logic [2:0][7:0]  ow;
      logic [2:0]       ov;
      logic [2:0][6:0]  ok;
      logic [6:0]       base;
      logic [6:0]       ek;
      logic             hit;
      s     = s_i;
      r     = RES_DONE;
      em    = 1'b0;
      t     = '0;
      ek    = K_EOF;
      l     = b | 8'h20;
      op_en = 1'b0;
      ow    = '0;
      ov    = '0;
      ok    = '0;
      base  = K_EOF;
      hit   = 1'b0;
      w     = 2'(s.mode - M_IDE);
      case (s.mode)
         M_IDLE: begin
            s.tfo = s.co;
            s.tfl = s.cl;
            s.tfc = s.cc;
            if (e) begin
               em = 1'b1;
               ek = K_EOF;
            end else begin
               s = commit(s, b);
               if (is_ws(b)) s.mode = M_WS;
               else if (b == "/") s.mode = M_SLASH;
               else if (is_digit(b)) s.mode = (b == "0") ? M_ZERO : M_DEC;
               else if (b == ".") s.mode = M_DOT;
               else if (b == "'" || b == "\"") begin
                  s.qdbl = (b == "\"");
                  s.mode = M_STRING;
               end else if ((l >= "a" && l <= "z") || b == "_") begin
                  s.kwp  = 3'd0;
                  s.mode = (b == "e") ? M_IDE : (b == "f") ? M_IDF :
                           (b == "i") ? M_IDI : M_IDX;
               end else begin
                  em = 1'b1;
                  case (b)
                     "~":     ek = K_TILDE;
                     "(":     ek = K_LPAREN;
                     ")":     ek = K_RPAREN;
                     "[":     ek = K_LSQ;
                     "]":     ek = K_RSQ;
                     "{":     ek = K_LBRACE;
                     "}":     ek = K_RBRACE;
                     ";":     ek = K_SEMI;
                     ",":     ek = K_COMMA;
                     "?":     ek = K_QUESTION;
                     "!":     begin em = 1'b0; s.mode = M_EXCL; end
                     "%":     begin em = 1'b0; s.mode = M_PERCENT; end
                     "^":     begin em = 1'b0; s.mode = M_HAT; end
                     "&":     begin em = 1'b0; s.mode = M_AMP; end
                     "*":     begin em = 1'b0; s.mode = M_STAR; end
                     "-":     begin em = 1'b0; s.mode = M_MINUS; end
                     "+":     begin em = 1'b0; s.mode = M_PLUS; end
                     "=":     begin em = 1'b0; s.mode = M_EQ; end
                     "|":     begin em = 1'b0; s.mode = M_OR; end
                     ":":     begin em = 1'b0; s.mode = M_COLON; end
                     "<":     begin em = 1'b0; s.mode = M_LESS; end
                     ">":     begin em = 1'b0; s.mode = M_GREATER; end
                     default: ek = K_INVALID;
                  endcase
               end
            end
         end
         M_WS: begin
            if (!e && is_ws(b)) s = commit(s, b);
            else begin em = 1'b1; ek = K_WS; r = RES_AGAIN; end
         end
         M_SLASH: begin
            if (!e && b == "/") begin
               s = commit(s, b);
               s.mode = M_LINECOM;
            end else if (!e && b == "*") begin
               s = commit(s, b);
               s.mode = M_BLOCKCOM;
            end else begin
               op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_SLASHEQ; base = K_SLASH;
            end
         end
         M_LINECOM: begin
            if (e) begin em = 1'b1; ek = K_LINECOM; r = RES_AGAIN; end
            else begin
               s = commit(s, b);
               if (b == "\n") begin em = 1'b1; ek = K_LINECOM; end
            end
         end
         M_BLOCKCOM, M_BLOCKSTAR: begin
            if (e) begin em = 1'b1; ek = K_BLOCKCOM; r = RES_AGAIN; end
            else begin
               s = commit(s, b);
               if (s.mode == M_BLOCKSTAR && b == "/") begin em = 1'b1; ek = K_BLOCKCOM; end
               else s.mode = (b == "*") ? M_BLOCKSTAR : M_BLOCKCOM;
            end
         end
         M_ZERO, M_DEC: begin
            if (s.mode == M_ZERO && !e && l == "x") begin
               s.held = b; s.hcnt = 1'b1; s.mode = M_HEXPRE;
            end else if (s.mode == M_ZERO && !e && l == "b") begin
               s.held = b; s.hcnt = 1'b1; s.mode = M_BINPRE;
            end else if (!e && is_digit(b)) begin
               s = commit(s, b);
               s.mode = M_DEC;
            end else if (!e && b == ".") begin
               s = commit(s, b);
               s.mode = M_DECPART;
            end else begin
               em = 1'b1; ek = K_INT; r = RES_AGAIN;
            end
         end
         M_DECPART: begin
            if (!e && is_digit(b)) s = commit(s, b);
            else begin
               op_en = 1'b1; ov = 3'b001; ow[0] = "f"; ok[0] = K_FLOAT; base = K_DOUBLE;
            end
         end
         M_HEXPRE: begin
            if (!e && is_hex(b)) begin
               s = commit(s, s.held);
               s.held = 8'h00; s.hcnt = 1'b0;
               s = commit(s, b);
               s.mode = M_HEX;
            end else begin
               em = 1'b1; ek = K_INT; r = RES_HELD;
            end
         end
         M_HEX: begin
            if (!e && is_hex(b)) s = commit(s, b);
            else begin em = 1'b1; ek = K_HEX; r = RES_AGAIN; end
         end
         M_BINPRE: begin
            if (!e && (b == "0" || b == "1")) begin
               s = commit(s, s.held);
               s.held = 8'h00; s.hcnt = 1'b0;
               s = commit(s, b);
               s.mode = M_BIN;
            end else begin
               em = 1'b1; ek = K_INT; r = RES_HELD;
            end
         end
         M_BIN: begin
            if (!e && (b == "0" || b == "1")) s = commit(s, b);
            else begin em = 1'b1; ek = K_BIN; r = RES_AGAIN; end
         end
         M_DOT: begin
            if (!e && is_digit(b)) begin
               s = commit(s, b);
               s.mode = M_DECPART;
            end else if (!e && b == ".") begin
               s = commit(s, b);
               s.mode = M_DOTDOT;
            end else begin
               em = 1'b1; ek = K_DOT; r = RES_AGAIN;
            end
         end
         M_DOTDOT: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = "."; ok[0] = K_DOT3; base = K_DOT2;
         end
         M_STRING: begin
            if (e) begin em = 1'b1; ek = K_STRING; r = RES_AGAIN; end
            else begin
               s = commit(s, b);
               if (b == (s.qdbl ? 8'h22 : 8'h27)) begin em = 1'b1; ek = K_STRING; end
            end
         end
         M_IDE, M_IDF, M_IDI, M_IDX: begin
            if (!e && ident_cont(b)) begin
               if (w != 2'd3) begin
                  if (s.kwp < kw_len(w) && b == kw_char(w, s.kwp[1:0]))
                     s.kwp = s.kwp + 3'd1;
                  else
                     s.kwp = 3'd7;
               end
               s = commit(s, b);
            end else begin
               ek = (w != 2'd3 && s.kwp == kw_len(w)) ? kw_kind(w) : K_IDENT;
               s.kwp = 3'd0;
               em = 1'b1;
               r = RES_AGAIN;
            end
         end
         M_EXCL: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_EXCLEQ; base = K_EXCL;
         end
         M_PERCENT: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_PCTEQ; base = K_PCT;
         end
         M_HAT: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_HATEQ; base = K_HAT;
         end
         M_AMP: begin
            op_en = 1'b1; ov = 3'b011;
            ow[0] = "&"; ok[0] = K_ANDAND; ow[1] = "="; ok[1] = K_ANDEQ; base = K_AND;
         end
         M_STAR: begin
            if (!e && b == "*") begin
               s = commit(s, b);
               s.mode = M_STARSTAR;
            end else begin
               op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_STAREQ; base = K_STAR;
            end
         end
         M_STARSTAR: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_STARSTAREQ;
            base = K_STARSTAR;
         end
         M_MINUS: begin
            op_en = 1'b1; ov = 3'b111;
            ow[0] = "-"; ok[0] = K_MINUSMINUS; ow[1] = "="; ok[1] = K_MINUSEQ;
            ow[2] = ">"; ok[2] = K_ARROW; base = K_MINUS;
         end
         M_PLUS: begin
            op_en = 1'b1; ov = 3'b011;
            ow[0] = "+"; ok[0] = K_PLUSPLUS; ow[1] = "="; ok[1] = K_PLUSEQ; base = K_PLUS;
         end
         M_EQ: begin
            op_en = 1'b1; ov = 3'b011;
            ow[0] = "="; ok[0] = K_EQEQ; ow[1] = ">"; ok[1] = K_FATARROW; base = K_EQ;
         end
         M_OR: begin
            op_en = 1'b1; ov = 3'b011;
            ow[0] = "|"; ok[0] = K_OROR; ow[1] = "="; ok[1] = K_OREQ; base = K_OR;
         end
         M_COLON: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = ":"; ok[0] = K_COLCOL; base = K_COLON;
         end
         M_LESS: begin
            if (!e && b == "<") begin
               s = commit(s, b);
               s.mode = M_LESSLESS;
            end else if (!e && b == "-") begin
               s.held = b; s.hcnt = 1'b1; s.mode = M_LESSMINUS;
            end else begin
               op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_LE; base = K_LT;
            end
         end
         M_LESSLESS: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_SHLEQ; base = K_SHL;
         end
         M_LESSMINUS: begin
            if (!e && b == "<") begin
               s = commit(s, s.held);
               s.held = 8'h00; s.hcnt = 1'b0;
               s = commit(s, b);
               s.mode = M_LMLESS;
            end else begin
               em = 1'b1; ek = K_LT; r = RES_HELD;
            end
         end
         M_LMLESS: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_LMLEQ; base = K_LML;
         end
         M_GREATER: begin
            if (!e && b == ">") begin
               s = commit(s, b);
               s.mode = M_GTGT;
            end else if (!e && b == "-") begin
               s.held = b; s.hcnt = 1'b1; s.mode = M_GTMINUS;
            end else begin
               op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_GE; base = K_GT;
            end
         end
         M_GTGT: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_SHREQ; base = K_SHR;
         end
         M_GTMINUS: begin
            if (!e && b == ">") begin
               s = commit(s, s.held);
               s.held = 8'h00; s.hcnt = 1'b0;
               s = commit(s, b);
               s.mode = M_GMGT;
            end else begin
               em = 1'b1; ek = K_GT; r = RES_HELD;
            end
         end
         M_GMGT: begin
            op_en = 1'b1; ov = 3'b001; ow[0] = "="; ok[0] = K_GMGEQ; base = K_GMG;
         end
         default: begin
            s.mode = M_IDLE;
            r = RES_AGAIN;
         end
      endcase
      // operator with optional second byte
      if (op_en) begin
         for (int i = 0; i < 3; i++) begin
            if (!hit && ov[i] && !e && b == ow[i]) begin
               hit = 1'b1;
               ek  = ok[i];
            end
         end
         if (hit) s = commit(s, b);
         else begin
            ek = base;
            r  = RES_AGAIN;
         end
         em = 1'b1;
      end
      if (em) begin
         t = mk_tok(s, ek);
         s.mode = M_IDLE;
      end
   endfunction

   always_comb begin
      lex_state_type s;
      lex_state_type s_nx;
      logic          cur_e;
      logic [7:0]    cur_b;
      logic          pend;
      logic          pend_e;
      logic [7:0]    pend_b;
      logic          done;
      logic [1:0]    r;
      logic          em;
      tok_type       t;
      logic [1:0]    n;
      s      = st_ff;
      cur_e  = req_data.end_of_input;
      cur_b  = req_data.end_of_input ? 8'h00 : req_data.source_byte;
      pend   = 1'b0;
      pend_e = 1'b0;
      pend_b = 8'h00;
      done   = 1'b0;
      n      = 2'd0;
      entry  = '0;
      for (int i = 0; i < MAX_FEEDS; i++) begin
         if (!done) begin
            feed(s, cur_e, cur_b, s_nx, r, em, t);
            s = s_nx;
            if (em && n < 2'(MAX_TOKENS)) begin
               entry.toks[n] = t;
               n = n + 2'd1;
            end
            if (r == RES_DONE) begin
               if (pend) begin
                  cur_e = pend_e;
                  cur_b = pend_b;
                  pend  = 1'b0;
               end else begin
                  done = 1'b1;
               end
            end else if (r == RES_HELD && s.hcnt) begin
               // relex the held byte, then the current symbol
               pend   = 1'b1;
               pend_e = cur_e;
               pend_b = cur_b;
               cur_e  = 1'b0;
               cur_b  = s.held;
               s.held = 8'h00;
               s.hcnt = 1'b0;
            end
         end
      end
      entry.count = n;
      push  = accept && (n != 2'd0);
      st_in = accept ? s : st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== rtl/sct_queue.sv =====
// short queue of per-request token groups between lexer and output side
module sct_queue import sct_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output entry_type head
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/sct_emitter.sv =====
// back end: hands out the tokens of the queue head one at a time
module sct_emitter import sct_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  entry_type q_head,
   output logic      q_pop,
   output logic      empty,
   input  logic      pop,
   output rsp_type   rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       last;
   tok_type    t;

   assign t     = q_head.toks[idx_ff];
   assign last  = (idx_ff == 2'(q_head.count - 2'd1));
   assign empty = q_empty;
   assign q_pop = pop && !q_empty && last;

   assign rsp_data = '{token_kind:   t.token_kind,
                       start_offset: t.start_offset,
                       end_offset:   t.end_offset,
                       start_line:   t.start_line,
                       start_column: t.start_column,
                       last_of_run:  last};

   always_comb begin
      idx_in = idx_ff;
      if (pop && !q_empty) idx_in = last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== rtl/source_code_tokenizer.sv =====
// top level of the streaming source code tokenizer
//
//   channel   ports                          moves
//   request   push, full, req_data           one source byte or end of input
//   response  pop, empty, rsp_data           one token
//
// A request is taken in the cycle it arrives whenever the four-entry token queue
// has room, so bytes stream at one per cycle. Responses leave one token per pop; a
// request giving n tokens needs n pops on the output side, which the queue
// absorbs. full rises only when the queue holds four unfinished groups.
// Synchronous reset returns the lexer to idle with offset 0, line 1, column 1.
module source_code_tokenizer import sct_pkg::*; #(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic      lex_push;
   entry_type lex_entry;
   logic      q_pop;
   logic      q_empty;
   entry_type q_head;

   sct_lexer #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_lexer (
      .clock    (clock),
      .reset    (reset),
      .accept   (push && !full),
      .req_data (req_data),
      .push     (lex_push),
      .entry    (lex_entry)
   );

   sct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (lex_push),
      .push_data (lex_entry),
      .pop       (q_pop),
      .full      (full),
      .empty     (q_empty),
      .head      (q_head)
   );

   sct_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
